### sv/gfis_pkg.sv
// Shared types, constants and GF(2^8) helper functions for the S-box unit.
// Used by gfis_inv_pipe, gfis_affine_stage and gf256_inverse_sbox_unit.
package gfis_pkg;

  localparam int ByteW = 8;

  // Field polynomial x^8 + x^4 + x^3 + x + 1.
  localparam logic [ByteW:0]   FieldPoly      = 9'h11b;
  localparam logic [ByteW-1:0] AffineConst    = 8'h63;
  localparam logic             ApplyAffineRst = 1'b1;

  typedef logic [ByteW-1:0] byte_t;

  // Occupancy of the three inversion stages.
  typedef struct packed {
    logic s1_v;
    logic s2_v;
    logic s3_v;
  } pipe_stat_t;

  // Shift-and-add multiply with reduction after each shift.
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) begin
        acc = acc ^ aa;
      end
      aa = {aa[ByteW-2:0], 1'b0} ^ (aa[ByteW-1] ? FieldPoly[ByteW-1:0] : '0);
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2): spread the bits, then reduce.
  function automatic byte_t gf_sq(input byte_t a);
    logic [2*ByteW-2:0] w;
    w = '0;
    for (int i = 0; i < ByteW; i++) begin
      w[2*i] = a[i];
    end
    for (int i = 2*ByteW-2; i >= ByteW; i--) begin
      if (w[i]) begin
        w[i-ByteW +: ByteW+1] = w[i-ByteW +: ByteW+1] ^ FieldPoly;
      end
    end
    return w[ByteW-1:0];
  endfunction

  function automatic byte_t gf_affine(input byte_t b);
    return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ AffineConst;
  endfunction

endpackage

### sv/gfis_inv_pipe.sv
// Three-stage GF(2^8) inversion pipeline computing a^254 by an addition chain.
// Depends on gfis_pkg for the field multiply and squaring functions.
module gfis_inv_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gfis_pkg::byte_t        in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gfis_pkg::byte_t        out_inv,
  output gfis_pkg::pipe_stat_t   stat
);
  import gfis_pkg::*;

  logic  s1_v_r, s2_v_r, s3_v_r;
  logic  rdy1, rdy2, rdy3;
  byte_t s1_a3_r, s1_a4_r;
  byte_t s2_a15_r, s2_a7_r;
  byte_t s3_inv_r;
  byte_t s1_a3_nxt, s1_a4_nxt, s2_a15_nxt, s2_a7_nxt, s3_inv_nxt;

  // A stage may take a new request when it is empty or its content moves on.
  assign rdy3     = !s3_v_r || out_ready;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  // Chain: a^3, then a^15 and a^7, then a^240 * a^14 = a^254. Zero stays zero.
  always_comb begin
    s1_a3_nxt  = gf_mul(gf_sq(in_data), in_data);
    s1_a4_nxt  = gf_sq(gf_sq(in_data));
    s2_a15_nxt = gf_mul(gf_sq(gf_sq(s1_a3_r)), s1_a3_r);
    s2_a7_nxt  = gf_mul(s1_a4_r, s1_a3_r);
    s3_inv_nxt = gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(s2_a15_r)))), gf_sq(s2_a7_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_a3_r <= s1_a3_nxt;
      s1_a4_r <= s1_a4_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_a15_r <= s2_a15_nxt;
      s2_a7_r  <= s2_a7_nxt;
    end
    if (rdy3 && s2_v_r) begin
      s3_inv_r <= s3_inv_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_inv   = s3_inv_r;
  assign stat      = '{s1_v: s1_v_r, s2_v: s2_v_r, s3_v: s3_v_r};

endmodule

### sv/gfis_affine_stage.sv
// Output register stage applying the optional AES affine transform.
// Depends on gfis_pkg for the affine function and byte type.
module gfis_affine_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gfis_pkg::byte_t in_inv,
  input  logic            apply_affine,
  output logic            out_valid,
  input  logic            out_ready,
  output gfis_pkg::byte_t out_result
);
  import gfis_pkg::*;

  logic  out_v_r;
  byte_t out_data_r;
  byte_t out_data_nxt;

  assign in_ready     = !out_v_r || out_ready;
  assign out_data_nxt = apply_affine ? gf_affine(in_inv) : in_inv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (in_ready) begin
      out_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_result = out_data_r;

endmodule

### sv/gf256_inverse_sbox_unit.sv
// GF(2^8) inverse / AES S-box unit: each request byte is inverted modulo 0x11b
// (zero maps to zero) and, when cfg apply_affine is set, passed through the AES
// affine transform to give the forward S-box value. The unit takes one request
// per clock while in_ready is high; out_valid rises once the request has passed
// the three field-multiply stages of the inversion chain and then the output
// register, the first stage being loaded at the accepting edge itself.
// Each stage stalls independently, so bubbles are filled and a full pipeline
// holds four requests while out_ready is low. The mode register resets to 1.
// Depends on gfis_pkg, gfis_inv_pipe and gfis_affine_stage.
module gf256_inverse_sbox_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  gfis_pkg::byte_t in_data_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output gfis_pkg::byte_t out_result_byte
);
  import gfis_pkg::*;

  logic       apply_affine_r;
  logic       inv_valid, inv_ready;
  byte_t      inv_data;
  pipe_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_affine_r <= ApplyAffineRst;
    end else if (cfg_wr_en) begin
      apply_affine_r <= cfg_wr_data;
    end
  end

  gfis_inv_pipe u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data_byte),
    .out_valid (inv_valid),
    .out_ready (inv_ready),
    .out_inv   (inv_data),
    .stat      (stat)
  );

  gfis_affine_stage u_aff (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (inv_valid),
    .in_ready     (inv_ready),
    .in_inv       (inv_data),
    .apply_affine (apply_affine_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (out_result_byte)
  );

`ifndef SYNTH
  // An empty output register means every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while the output stage is empty");

  // A full, stalled pipeline must refuse new requests.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.s1_v && stat.s2_v && stat.s3_v && out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted into a full stalled pipeline");

  // A result can only appear from an occupied last inversion stage.
  a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.s3_v))
    else $error("out_valid rose without a request in the last stage");
`endif

endmodule

### tb/sv/gf256_inverse_sbox_unit_tb.sv
// Self-checking testbench for gf256_inverse_sbox_unit: field inverse and S-box
// requests under random idling, output back-pressure and mode changes.
// Depends on gfis_pkg and the unit's RTL.
module gf256_inverse_sbox_unit_tb;
  import gfis_pkg::byte_t;

  localparam int HoldOffCycles = 80;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_wr_en = 1'b0;
  logic  cfg_wr_data = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  byte_t in_data_byte = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_result_byte;

  // Local copy of the mode register; it resets to S-box mode.
  logic  affine_mode = 1'b1;
  byte_t pending_results[$];
  byte_t expected_byte;
  int    mismatch_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_off_requests = 0;
  int    hold_off_served = 0;
  int    hold_off_left = 0;
  int    idle_cycles = 0;

  gf256_inverse_sbox_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_byte(out_result_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Multiply in GF(2^8): double one operand per bit, folding x^8 back in.
  function automatic byte_t field_mul(input byte_t a, input byte_t b);
    byte_t product;
    byte_t doubled;
    product = '0;
    doubled = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        product ^= doubled;
      end
      doubled = doubled[7] ? ((doubled << 1) ^ 8'h1b) : (doubled << 1);
    end
    return product;
  endfunction

  // a^254 as the product a^2 * a^4 * ... * a^128; zero stays zero.
  function automatic byte_t field_inverse(input byte_t a);
    byte_t power;
    byte_t inverse;
    power = a;
    inverse = 8'h01;
    for (int k = 1; k < 8; k++) begin
      power = field_mul(power, power);
      inverse = field_mul(inverse, power);
    end
    return inverse;
  endfunction

  // Each output bit is the input bit XOR the four bits at rotations 1..4 below it.
  function automatic byte_t sbox_affine(input byte_t b);
    byte_t mixed;
    for (int k = 0; k < 8; k++) begin
      mixed[k] = b[k] ^ b[(k + 7) % 8] ^ b[(k + 6) % 8] ^ b[(k + 5) % 8] ^ b[(k + 4) % 8];
    end
    return mixed ^ 8'h63;
  endfunction

  function automatic byte_t predict_result(input byte_t data, input logic use_affine);
    byte_t inverse;
    inverse = field_inverse(data);
    return use_affine ? sbox_affine(inverse) : inverse;
  endfunction

  task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
    $display("mismatch: %s, got %02h expected %02h (mode %0d)", what, got, want,
             affine_mode);
    mismatch_count++;
  endtask

  // Receiver: random ready, overridden by a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_requests;
      hold_off_left <= HoldOffCycles - 1;
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Predict on every accepted request and check every accepted result in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", out_result_byte, '0);
        end else begin
          expected_byte = pending_results.pop_front();
          if (out_result_byte !== expected_byte) begin
            report_mismatch("result_byte", out_result_byte, expected_byte);
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_result(in_data_byte, affine_mode));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input byte_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Only called with the unit empty, so no request is in flight under the old mode.
  task automatic set_mode(input logic mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    affine_mode = mode;
  endtask

  task automatic send_corner_bytes();
    byte_t corners[12] = '{8'h00, 8'h01, 8'h02, 8'h80, 8'hff, 8'hfe,
                           8'h53, 8'hca, 8'h55, 8'haa, 8'h0f, 8'hf0};
    foreach (corners[k]) begin
      send_request(corners[k]);
    end
  endtask

  // Zero has no inverse; it must come out as 0x63 in S-box mode.
  task automatic test_directed_sbox();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_corner_bytes();
    wait_until_drained();
  endtask

  task automatic test_directed_inverse();
    set_mode(1'b0);
    send_corner_bytes();
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input logic mode, input int send_pct, input int recv_pct,
                                     input int count);
    set_mode(mode);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      send_request(byte_t'($urandom_range(0, 255)));
    end
    wait_until_drained();
  endtask

  // Hold the output off long enough for the pipeline to fill and stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_requests <= hold_off_requests + 1;
    repeat (24) begin
      send_request(byte_t'($urandom_range(0, 255)));
    end
    wait_until_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 20;
    repeat (3) begin
      repeat (12) begin
        send_request(byte_t'($urandom_range(0, 255)));
      end
      wait_until_drained();
    end
  endtask

  initial begin
    repeat (SettleCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_sbox();
    test_directed_inverse();
    test_random_traffic(1'b1, 35, 58, 560);
    test_random_traffic(1'b0, 58, 35, 560);
    test_random_traffic(1'b1, 0, 0, 350);
    test_output_backpressure();
    set_mode(1'b0);
    test_drain_pause();

    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### gf256_inverse_sbox_unit.f
sv/gfis_pkg.sv
sv/gfis_inv_pipe.sv
sv/gfis_affine_stage.sv
sv/gf256_inverse_sbox_unit.sv
tb/sv/gf256_inverse_sbox_unit_tb.sv
